// ===== design/lapf_pkg.sv =====
// Shared types and constants for the Laplacian luma filter.
package lapf_pkg;

  // Field widths
  localparam int LUMA_W     = 8;
  localparam int POS_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USED_W = 2 * POS_W + LUMA_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Register reset value and smallest usable frame size
  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 10'd512;
  localparam int                    SIZE_MIN   = 3;

  // Mid-scale offset added to the Laplacian
  localparam logic [LUMA_W-1:0] BIAS = 8'd128;

  // Per-sample control captured at the input register
  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  py;
    logic [LUMA_W-1:0] luma;
    logic              has_a;
    logic              last_line;
    logic              border;
    logic              done_a;
    logic              done_b;
  } pix_ctl_t;

  // Neighbours read from the line stores and window
  typedef struct packed {
    logic [LUMA_W-1:0] up;
    logic [LUMA_W-1:0] centre;
    logic [LUMA_W-1:0] left;
    logic [LUMA_W-1:0] right;
  } taps_t;

  // One result beat
  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [LUMA_W-1:0] value;
    logic              run_end;
    logic              frame_done;
  } result_t;

endpackage

// ===== design/laplacian_luma_filter.sv =====
// Top level of the 4-neighbour Laplacian filter on a raster luma stream.
// One luma sample per beat enters in raster order; each sample on line y >= 1
// yields the result for the pixel one line above it, and samples on the last
// line also yield a zero border result for themselves, so the first line
// yields nothing. A sample enters every cycle while one result per sample is
// due and out_tready is high; on the last line of a frame two results per
// sample share the single result port, so a sample there is taken only as the
// last result of the sample before it drains. A beat passes through the input
// register and then the result register. Two line stores of MAX_WIDTH x 8 bits
// hold the previous lines; the newer one has two read ports (centre and right
// neighbour). Border pixels give 0, interior pixels give the Laplacian plus 128
// modulo 256. Frame size registers (index 0 width, index 1 height) are clamped
// to 3..MAX and must be written only while the block is idle.
module laplacian_luma_filter #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [7:0] luma
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lapf_pkg::LUMA_W-1:0]        in_tdata,
  // out_tdata: [8:0] out_x, [17:9] out_y, [25:18] value, [31:26] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lapf_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  // out_tuser: [0] frame_done
  output logic                               out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lapf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lapf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SW_LO = $clog2(MAX_WIDTH + 1);
  localparam int SH_LO = $clog2(MAX_HEIGHT + 1);
  localparam int SW    = (SW_LO > lapf_pkg::CFG_DATA_W) ? SW_LO : lapf_pkg::CFG_DATA_W;
  localparam int SH    = (SH_LO > lapf_pkg::CFG_DATA_W) ? SH_LO : lapf_pkg::CFG_DATA_W;

  logic [lapf_pkg::CFG_DATA_W-1:0] frame_width_r;
  logic [lapf_pkg::CFG_DATA_W-1:0] frame_height_r;
  logic [CW-1:0]                   col_r;
  logic [CW-1:0]                   col_nxt;
  logic [LW-1:0]                   row_r;
  logic [LW-1:0]                   row_nxt;
  logic                            s1_vld_r;
  lapf_pkg::pix_ctl_t              s1_ctl_r;
  lapf_pkg::pix_ctl_t              ctl_nxt;

  logic [SW-1:0]     w_eff;
  logic [SH-1:0]     h_eff;
  logic [SW-1:0]     x_w;
  logic [SH-1:0]     y_h;
  logic              x_end;
  logic              in_fire;
  logic              s1_take;
  lapf_pkg::taps_t   taps;
  lapf_pkg::result_t res0;
  lapf_pkg::result_t res1;
  lapf_pkg::result_t head;
  logic [1:0]        n_res;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= lapf_pkg::SIZE_RESET;
      frame_height_r <= lapf_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lapf_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        lapf_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
      endcase
    end
  end

  // Clamp frame size to the supported range
  always_comb begin
    if (SW'(frame_width_r) < SW'(lapf_pkg::SIZE_MIN)) begin
      w_eff = SW'(lapf_pkg::SIZE_MIN);
    end else if (SW'(frame_width_r) > SW'(MAX_WIDTH)) begin
      w_eff = SW'(MAX_WIDTH);
    end else begin
      w_eff = SW'(frame_width_r);
    end
    if (SH'(frame_height_r) < SH'(lapf_pkg::SIZE_MIN)) begin
      h_eff = SH'(lapf_pkg::SIZE_MIN);
    end else if (SH'(frame_height_r) > SH'(MAX_HEIGHT)) begin
      h_eff = SH'(MAX_HEIGHT);
    end else begin
      h_eff = SH'(frame_height_r);
    end
  end

  assign x_w     = SW'(col_r);
  assign y_h     = SH'(row_r);
  assign x_end   = (x_w >= w_eff - SW'(1));
  assign in_fire = in_tvalid && in_tready;

  // Classify the incoming sample's position
  always_comb begin
    ctl_nxt.x         = lapf_pkg::POS_W'(col_r);
    ctl_nxt.y         = lapf_pkg::POS_W'(row_r);
    ctl_nxt.py        = lapf_pkg::POS_W'(row_r) - lapf_pkg::POS_W'(1);
    ctl_nxt.luma      = in_tdata;
    ctl_nxt.has_a     = (row_r != '0);
    ctl_nxt.last_line = (y_h >= h_eff - SH'(1));
    ctl_nxt.border    = (col_r == '0) || (y_h == SH'(1)) || x_end || (y_h >= h_eff);
    ctl_nxt.done_a    = x_end && (y_h == h_eff);
    ctl_nxt.done_b    = x_end && (y_h == h_eff - SH'(1));
  end

  // Advance the raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (x_w + SW'(1) >= w_eff) begin
      col_nxt = '0;
      if (y_h + SH'(1) >= h_eff) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_r + LW'(1);
      end
    end else begin
      col_nxt = col_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_take) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ctl_r <= ctl_nxt;
    end
  end

  assign in_tready = !s1_vld_r || s1_take;

  lapf_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .wr_en   (s1_take),
    .wr_luma (s1_ctl_r.luma),
    .taps    (taps)
  );

  lapf_kernel u_kernel (
    .ctl   (s1_ctl_r),
    .taps  (taps),
    .res0  (res0),
    .res1  (res1),
    .n_res (n_res)
  );

  lapf_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_vld     (s1_vld_r),
    .n_res      (n_res),
    .res0       (res0),
    .res1       (res1),
    .s1_take    (s1_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  // Pack the result beat
  assign out_tdata = {{(lapf_pkg::OUT_DATA_W - lapf_pkg::OUT_USED_W){1'b0}},
                      head.value, head.y, head.x};
  assign out_tlast = head.run_end;
  assign out_tuser = head.frame_done;

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(col_r) < SW'(MAX_WIDTH))
    else $error("column counter beyond line store depth");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SH'(row_r) < SH'(MAX_HEIGHT))
    else $error("line counter beyond maximum height");

  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_vld_r)
    else $error("accepted beat missing from input register");

endmodule

// ===== design/lapf_line_store.sv =====
// Two line stores and the window taps that feed the 4-neighbour kernel.
module lapf_line_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  input  logic                       wr_en,
  input  logic [lapf_pkg::LUMA_W-1:0] wr_luma,
  output lapf_pkg::taps_t            taps
);

  logic [lapf_pkg::LUMA_W-1:0] older_mem [DEPTH];
  logic [lapf_pkg::LUMA_W-1:0] newer_mem [DEPTH];

  logic [lapf_pkg::LUMA_W-1:0] up_r;
  logic [lapf_pkg::LUMA_W-1:0] centre_r;
  logic [lapf_pkg::LUMA_W-1:0] left_r;
  logic [lapf_pkg::LUMA_W-1:0] right_r;
  logic [AW-1:0]               wr_addr_r;
  logic [AW-1:0]               rd_addr_next;

  assign rd_addr_next = rd_addr + AW'(1);

  // Window taps: shift the previous centre into the left tap on each new beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r     <= '0;
      centre_r <= '0;
      left_r   <= '0;
    end else if (rd_en) begin
      up_r     <= older_mem[rd_addr];
      centre_r <= newer_mem[rd_addr];
      left_r   <= centre_r;
    end
  end

  // Right neighbour read and write address follow the same beat
  always_ff @(posedge clk) begin
    if (rd_en) begin
      right_r   <= newer_mem[rd_addr_next];
      wr_addr_r <= rd_addr;
    end
  end

  // Roll the column down one line when the beat leaves the input register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr_r] <= centre_r;
      newer_mem[wr_addr_r] <= wr_luma;
    end
  end

  assign taps.up     = up_r;
  assign taps.centre = centre_r;
  assign taps.left   = left_r;
  assign taps.right  = right_r;

endmodule

// ===== design/lapf_kernel.sv =====
// Laplacian arithmetic and result selection for one sample.
module lapf_kernel (
  input  lapf_pkg::pix_ctl_t ctl,
  input  lapf_pkg::taps_t    taps,
  output lapf_pkg::result_t  res0,
  output lapf_pkg::result_t  res1,
  output logic [1:0]         n_res
);

  logic [lapf_pkg::LUMA_W-1:0] lap;
  lapf_pkg::result_t           res_a;
  lapf_pkg::result_t           res_b;

  // Sum of four neighbours minus four centres plus offset, wrapping at 8 bits
  assign lap = taps.up + ctl.luma + taps.left + taps.right + lapf_pkg::BIAS
             - {taps.centre[lapf_pkg::LUMA_W-3:0], 2'b00};

  // Result for the pixel one line up
  always_comb begin
    res_a.x          = ctl.x;
    res_a.y          = ctl.py;
    res_a.value      = ctl.border ? '0 : lap;
    res_a.run_end    = !ctl.last_line;
    res_a.frame_done = ctl.done_a;
  end

  // Border result for the pixel itself on the last line
  always_comb begin
    res_b.x          = ctl.x;
    res_b.y          = ctl.y;
    res_b.value      = '0;
    res_b.run_end    = 1'b1;
    res_b.frame_done = ctl.done_b;
  end

  assign res0  = ctl.has_a ? res_a : res_b;
  assign res1  = res_b;
  assign n_res = {1'b0, ctl.has_a} + {1'b0, ctl.last_line};

endmodule

// ===== design/lapf_out_buf.sv =====
// Two-entry result register that drains one beat per cycle while out_tready is high.
module lapf_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_vld,
  input  logic [1:0]        n_res,
  input  lapf_pkg::result_t res0,
  input  lapf_pkg::result_t res1,
  output logic              s1_take,
  output logic              out_tvalid,
  input  logic              out_tready,
  output lapf_pkg::result_t head
);

  logic [1:0]        cnt_r;
  logic [1:0]        cnt_nxt;
  lapf_pkg::result_t a_r;
  lapf_pkg::result_t a_nxt;
  lapf_pkg::result_t b_r;
  lapf_pkg::result_t b_nxt;
  logic              pop;
  logic              load;

  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;

  // Take the sample when its results fit behind what drains this cycle
  assign s1_take = s1_vld && ((n_res == 2'd0) || (cnt_r == 2'd0) ||
                              ((cnt_r == 2'd1) && pop));
  assign load    = s1_take && (n_res != 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    if (load) begin
      cnt_nxt = n_res;
      a_nxt   = res0;
      b_nxt   = res1;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      a_nxt   = b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign head = a_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result count out of range");

  a_pair_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) && pop |=> (cnt_r == 2'd1))
    else $error("pair did not drain to one entry");

  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ((cnt_r == 2'd0) || pop))
    else $error("results loaded over a pending beat");

endmodule
